// ===== design/b2da_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// b2da_pkg
// Shared widths, constants and controller/datapath command types for the
// binary to decimal ascii converter.
// ---------------------------------------------------------------------------
package b2da_pkg;

  // field widths
  localparam int unsigned VALUE_W    = 16;
  localparam int unsigned CHAR_W     = 6;
  localparam int unsigned NUM_DIGITS = 5;
  localparam int unsigned DIGIT_W    = 4;
  localparam int unsigned BCD_W      = NUM_DIGITS * DIGIT_W;
  localparam int unsigned POS_W      = 3;
  localparam int unsigned ITER_W     = 4;

  // one shift-add-3 step per input bit
  localparam logic [ITER_W-1:0] LAST_ITER = ITER_W'(VALUE_W - 1);

  // ascii '0' is 6'b110000, so a digit char is the digit under these two bits
  localparam logic [CHAR_W-DIGIT_W-1:0] ASCII_ZERO_HI = 2'b11;

  // bcd digit correction threshold and offset
  localparam logic [DIGIT_W-1:0] DD_THRESH = 4'd5;
  localparam logic [DIGIT_W-1:0] DD_ADD    = 4'd3;

  // controller to datapath commands
  typedef struct packed {
    logic load;
    logic shift;
    logic set_pos;
    logic dec_pos;
  } dp_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic pos_zero;
  } dp_stat_t;

endpackage

// ===== design/b2da_if.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// b2da_if
// Valid/ready channels: input value channel and output character channel.
// ---------------------------------------------------------------------------
interface b2da_in_if;
  logic                            valid;
  logic                            ready;
  logic [b2da_pkg::VALUE_W-1:0]    value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface b2da_out_if;
  logic                            valid;
  logic                            ready;
  logic [b2da_pkg::CHAR_W-1:0]     digit_char;
  logic                            last;

  modport source (output valid, output digit_char, output last, input ready);
  modport sink   (input valid, input digit_char, input last, output ready);
endinterface

// ===== design/b2da_datapath.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// b2da_datapath
// Double-dabble shift register, digit pointer and character formatting.
// ---------------------------------------------------------------------------
module b2da_datapath (
  input  logic                           clk,
  input  logic                           rst_n,
  input  b2da_pkg::dp_cmd_t              cmd,
  input  logic [b2da_pkg::VALUE_W-1:0]   value,
  output b2da_pkg::dp_stat_t             stat,
  output logic [b2da_pkg::CHAR_W-1:0]    digit_char,
  output logic                           last
);
  import b2da_pkg::*;

  logic [VALUE_W-1:0] bin_r, bin_nxt;
  logic [BCD_W-1:0]   bcd_r, bcd_nxt;
  logic [POS_W-1:0]   pos_r, pos_nxt;
  logic [BCD_W-1:0]   bcd_adj;
  logic [POS_W-1:0]   top_pos;
  logic               found;
  logic [DIGIT_W-1:0] cur_digit;

  // add 3 to every digit of 5 or more before the shift
  always_comb begin
    for (int d = 0; d < NUM_DIGITS; d++) begin
      if (bcd_r[d*DIGIT_W +: DIGIT_W] >= DD_THRESH) begin
        bcd_adj[d*DIGIT_W +: DIGIT_W] = bcd_r[d*DIGIT_W +: DIGIT_W] + DD_ADD;
      end else begin
        bcd_adj[d*DIGIT_W +: DIGIT_W] = bcd_r[d*DIGIT_W +: DIGIT_W];
      end
    end
  end

  // highest nonzero digit, never below the units digit
  always_comb begin
    top_pos = '0;
    found   = 1'b0;
    for (int d = NUM_DIGITS - 1; d > 0; d--) begin
      if (!found && (bcd_r[d*DIGIT_W +: DIGIT_W] != '0)) begin
        top_pos = POS_W'(d);
        found   = 1'b1;
      end
    end
  end

  // next-state of the shift register and pointer
  always_comb begin
    bin_nxt = bin_r;
    bcd_nxt = bcd_r;
    pos_nxt = pos_r;
    if (cmd.load) begin
      bin_nxt = value;
      bcd_nxt = '0;
    end else if (cmd.shift) begin
      bin_nxt = {bin_r[VALUE_W-2:0], 1'b0};
      bcd_nxt = {bcd_adj[BCD_W-2:0], bin_r[VALUE_W-1]};
    end
    if (cmd.set_pos) begin
      pos_nxt = top_pos;
    end else if (cmd.dec_pos) begin
      pos_nxt = pos_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bin_r <= '0;
      bcd_r <= '0;
      pos_r <= '0;
    end else begin
      bin_r <= bin_nxt;
      bcd_r <= bcd_nxt;
      pos_r <= pos_nxt;
    end
  end

  // character at the pointer
  assign cur_digit     = bcd_r[pos_r*DIGIT_W +: DIGIT_W];
  assign digit_char    = {ASCII_ZERO_HI, cur_digit};
  assign last          = (pos_r == '0);
  assign stat.pos_zero = (pos_r == '0);

endmodule

// ===== design/b2da_ctrl.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// b2da_ctrl
// Sequencer: accept a value, run the conversion steps, send the digits.
// ---------------------------------------------------------------------------
module b2da_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  b2da_pkg::dp_stat_t stat,
  output b2da_pkg::dp_cmd_t  cmd
);
  import b2da_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CONV = 2'd1;
  localparam logic [1:0] S_POS  = 2'd2;
  localparam logic [1:0] S_SEND = 2'd3;

  logic [1:0]        state_r, state_nxt;
  logic [ITER_W-1:0] cnt_r, cnt_nxt;

  // handshakes follow the state
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = (state_r == S_SEND);

  // datapath commands
  always_comb begin
    cmd.load    = in_valid && in_ready;
    cmd.shift   = (state_r == S_CONV);
    cmd.set_pos = (state_r == S_POS);
    cmd.dec_pos = out_valid && out_ready && !stat.pos_zero;
  end

  // state transitions
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      S_IDLE: begin
        cnt_nxt = '0;
        if (in_valid) begin
          state_nxt = S_CONV;
        end
      end
      S_CONV: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == LAST_ITER) begin
          state_nxt = S_POS;
        end
      end
      S_POS: begin
        state_nxt = S_SEND;
      end
      S_SEND: begin
        if (out_ready && stat.pos_zero) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

// ===== design/binary_to_decimal_ascii_core.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// binary_to_decimal_ascii_core
// Unsigned 16-bit value to decimal ASCII digits, most significant first.
// ---------------------------------------------------------------------------
// Each accepted item is a 16-bit unsigned value; the block answers with one
// to five items, each an ASCII digit '0'..'9' (6 bits) with last set on the
// units digit. Leading zeros are dropped, zero gives a single '0'. The value
// goes through a 16-step shift-add-3 (double dabble) loop, one step a cycle,
// then the S_POS state picks the first nonzero digit, and the digits go out
// one per cycle while out_ch.ready is high. One value is converted at a
// time, so the next value is accepted only after the last digit is sent.
module binary_to_decimal_ascii_core (
  input  logic       clk,
  input  logic       rst_n,
  b2da_in_if.sink    in_ch,
  b2da_out_if.source out_ch
);
  import b2da_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // sequencer
  b2da_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // conversion datapath
  b2da_datapath u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .value      (in_ch.value),
    .stat       (stat),
    .digit_char (out_ch.digit_char),
    .last       (out_ch.last)
  );

endmodule
